// ===== sv/ccly_pkg.sv =====
// ----------------------------------------------------------------------------
// ccly_pkg
// shared types, calendar constants and leap-year / month-length helpers
// ----------------------------------------------------------------------------
package ccly_pkg;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_SET  = 1'b1
  } ccly_op_t;

  typedef struct packed {
    ccly_op_t    opcode;
    logic [5:0]  set_second;
    logic [5:0]  set_minute;
    logic [4:0]  set_hour;
    logic [4:0]  set_day;
    logic [3:0]  set_month;
    logic [15:0] set_year;
  } ccly_in_t;

  typedef struct packed {
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [15:0] year;
    logic        set_error;
  } ccly_out_t;

  localparam logic [5:0] SEC_PER_MIN  = 6'd60;
  localparam logic [5:0] MIN_PER_HOUR = 6'd60;
  localparam logic [4:0] HOUR_PER_DAY = 5'd24;
  localparam logic [3:0] MONTHS       = 4'd12;
  localparam logic [3:0] FEBRUARY     = 4'd1;
  localparam logic [4:0] FEB_LEAP_LEN = 5'd29;

  localparam logic [4:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // y / 25 by reciprocal, exact for all 16-bit y
  localparam int unsigned  DIV25_SHIFT = 21;
  localparam logic [32:0]  DIV25_RECIP = 33'd83887;

  // divisible by 400 == divisible by 16 and by 25
  function automatic logic leap_year(input logic [15:0] y);
    logic [32:0] prod;
    logic [11:0] q;
    logic [15:0] q25;
    logic        div25;
    prod  = {17'b0, y} * DIV25_RECIP;
    q     = prod[DIV25_SHIFT +: 12];
    q25   = {q, 4'b0} + {1'b0, q, 3'b0} + {4'b0, q};
    div25 = (q25 == y);
    return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
  endfunction

  function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    if (m >= MONTHS) begin
      len = 5'd0;
    end else if (m == FEBRUARY && leap) begin
      len = FEB_LEAP_LEN;
    end else begin
      len = MONTH_LEN[m];
    end
    return len;
  endfunction

endpackage

// ===== sv/ccly_core.sv =====
// ----------------------------------------------------------------------------
// ccly_core
// time-of-day and date counters with tick carry chain and set validation
// ----------------------------------------------------------------------------
module ccly_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  ccly_pkg::ccly_in_t  item,
  output ccly_pkg::ccly_out_t res
);
  import ccly_pkg::*;

  logic [5:0]  sec_r,   sec_nxt;
  logic [5:0]  min_r,   min_nxt;
  logic [4:0]  hour_r,  hour_nxt;
  logic [4:0]  day_r,   day_nxt;
  logic [3:0]  month_r, month_nxt;
  logic [15:0] year_r,  year_nxt;
  logic        err;
  logic        set_ok;
  logic [4:0]  cur_len;
  logic [4:0]  set_len;
  logic [5:0]  sec_inc;
  logic [5:0]  min_inc;
  logic [4:0]  hour_inc;
  logic [5:0]  day_inc;
  logic [3:0]  month_inc;

  assign cur_len   = days_in(month_r, leap_year(year_r));
  assign set_len   = days_in(item.set_month, leap_year(item.set_year));
  assign sec_inc   = sec_r + 6'd1;
  assign min_inc   = min_r + 6'd1;
  assign hour_inc  = hour_r + 5'd1;
  assign day_inc   = {1'b0, day_r} + 6'd1;
  assign month_inc = month_r + 4'd1;
  assign set_ok    = (item.set_month < MONTHS) && (item.set_hour < HOUR_PER_DAY)
                  && (item.set_minute < MIN_PER_HOUR) && (item.set_second < SEC_PER_MIN)
                  && (item.set_day < set_len);

  always_comb begin
    sec_nxt   = sec_r;
    min_nxt   = min_r;
    hour_nxt  = hour_r;
    day_nxt   = day_r;
    month_nxt = month_r;
    year_nxt  = year_r;
    err       = 1'b0;
    case (item.opcode)
      OP_TICK: begin
        sec_nxt = sec_inc;
        if (sec_inc >= SEC_PER_MIN) begin
          sec_nxt = 6'd0;
          min_nxt = min_inc;
          if (min_inc >= MIN_PER_HOUR) begin
            min_nxt  = 6'd0;
            hour_nxt = hour_inc;
            if (hour_inc >= HOUR_PER_DAY) begin
              hour_nxt = 5'd0;
              day_nxt  = day_inc[4:0];
              if (day_inc >= {1'b0, cur_len}) begin
                day_nxt   = 5'd0;
                month_nxt = month_inc;
                if (month_inc >= MONTHS) begin
                  month_nxt = 4'd0;
                  year_nxt  = year_r + 16'd1;
                end
              end
            end
          end
        end
      end
      OP_SET: begin
        if (set_ok) begin
          sec_nxt   = item.set_second;
          min_nxt   = item.set_minute;
          hour_nxt  = item.set_hour;
          day_nxt   = item.set_day;
          month_nxt = item.set_month;
          year_nxt  = item.set_year;
        end else begin
          err = 1'b1;
        end
      end
      default: begin
        err = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_r   <= '0;
      min_r   <= '0;
      hour_r  <= '0;
      day_r   <= '0;
      month_r <= '0;
      year_r  <= '0;
    end else if (step) begin
      sec_r   <= sec_nxt;
      min_r   <= min_nxt;
      hour_r  <= hour_nxt;
      day_r   <= day_nxt;
      month_r <= month_nxt;
      year_r  <= year_nxt;
    end
  end

  assign res = '{second: sec_nxt, minute: min_nxt, hour: hour_nxt, day: day_nxt,
                 month: month_nxt, year: year_nxt, set_error: err};

endmodule

// ===== sv/calendar_clock_leap_year.sv =====
// ----------------------------------------------------------------------------
// calendar_clock_leap_year
// calendar clock with gregorian leap years: tick and set words in, time out
// each word passes through the input register, then the result register, from in to out
// throughput: one word per cycle; both registers advance together when out is free
// the calendar counters update as a word moves from the input to the result register
// reset: synchronous active-low rst_n empties both registers and clears the time to zero
// ----------------------------------------------------------------------------
module calendar_clock_leap_year (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ccly_pkg::ccly_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ccly_pkg::ccly_out_t out_data
);
  import ccly_pkg::*;

  logic      in_vld_r, in_vld_nxt;
  ccly_in_t  in_dat_r;
  logic      out_vld_r, out_vld_nxt;
  ccly_out_t out_dat_r;
  ccly_out_t res;
  logic      adv;

  assign adv      = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || adv;

  always_comb begin
    in_vld_nxt  = in_vld_r;
    out_vld_nxt = out_vld_r;
    if (in_ready) begin
      in_vld_nxt = in_valid;
    end
    if (adv) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_dat_r <= in_data;
    end
    if (adv) begin
      out_dat_r <= res;
    end
  end

  ccly_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (adv),
    .item  (in_dat_r),
    .res   (res)
  );

  assign out_valid = out_vld_r;
  assign out_data  = out_dat_r;

endmodule

// ===== sv/ccly_checker.sv =====
// ----------------------------------------------------------------------------
// ccly_checker
// port-level checks on the calendar clock, bound to the top level
// ----------------------------------------------------------------------------
module ccly_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input ccly_pkg::ccly_out_t out_data
);
  import ccly_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled out word changed");

  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> ##2 out_valid)
    else $error("accepted word produced no out word");

  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.second < SEC_PER_MIN && out_data.minute < MIN_PER_HOUR
      && out_data.hour < HOUR_PER_DAY && out_data.month < MONTHS)
    else $error("time field out of range");

  a_day_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.day < days_in(out_data.month, leap_year(out_data.year)))
    else $error("day beyond month length");

endmodule

bind calendar_clock_leap_year ccly_checker u_ccly_checker (.*);

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the calendar clock with Gregorian leap years.
// It sends tick and set words, with random idle bursts on both channels.
// A calendar model inside the bench predicts the time word for each accepted
// word, and each result word is checked field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;
  import ccly_pkg::*;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  ccly_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  ccly_out_t out_data;

  bit        idle_on   = 1'b1;
  bit        failed    = 1'b0;

  // predicted calendar state
  logic [5:0]  cal_sec   = '0;
  logic [5:0]  cal_min   = '0;
  logic [4:0]  cal_hour  = '0;
  logic [4:0]  cal_day   = '0;
  logic [3:0]  cal_month = '0;
  logic [15:0] cal_year  = '0;

  ccly_out_t   expected_time_q [$];

  calendar_clock_leap_year DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic bit is_leap_year(input logic [15:0] y);
    int unsigned yy;
    yy = y;
    return ((yy % 4) == 0 && (yy % 100) != 0) || ((yy % 400) == 0);
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] m, input logic [15:0] y);
    logic [4:0] len;
    case (m)
      4'd1:                   len = is_leap_year(y) ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
      4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
      default:                len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic ccly_out_t advance_calendar(input ccly_in_t w);
    ccly_out_t r;
    bit        ok;
    r.set_error = 1'b0;
    if (w.opcode == OP_TICK) begin
      if (cal_sec < 6'd59) begin
        cal_sec++;
      end else begin
        cal_sec = '0;
        if (cal_min < 6'd59) begin
          cal_min++;
        end else begin
          cal_min = '0;
          if (cal_hour < 5'd23) begin
            cal_hour++;
          end else begin
            cal_hour = '0;
            if (cal_day + 5'd1 < month_days(cal_month, cal_year)) begin
              cal_day++;
            end else begin
              cal_day = '0;
              if (cal_month < 4'd11) begin
                cal_month++;
              end else begin
                cal_month = '0;
                cal_year++;
              end
            end
          end
        end
      end
    end else begin
      ok = w.set_month < 4'd12 && w.set_hour < 5'd24 && w.set_minute < 6'd60 &&
           w.set_second < 6'd60 && w.set_day < month_days(w.set_month, w.set_year);
      if (ok) begin
        cal_sec   = w.set_second;
        cal_min   = w.set_minute;
        cal_hour  = w.set_hour;
        cal_day   = w.set_day;
        cal_month = w.set_month;
        cal_year  = w.set_year;
      end else begin
        r.set_error = 1'b1;
      end
    end
    r.second = cal_sec;
    r.minute = cal_min;
    r.hour   = cal_hour;
    r.day    = cal_day;
    r.month  = cal_month;
    r.year   = cal_year;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      expected_time_q.push_back(advance_calendar(in_data));
    end
  end

  function automatic void check_field(input string name, input int unsigned exp_v,
                                      input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d actual %0d", name, exp_v, act_v);
      failed = 1'b1;
    end
  endfunction

  always @(posedge clk) begin
    ccly_out_t exp_t;
    if (rst_n && out_valid && out_ready) begin
      if (expected_time_q.size() == 0) begin
        $error("result word with no expected time waiting");
        failed = 1'b1;
      end else begin
        exp_t = expected_time_q.pop_front();
        check_field("second",    exp_t.second,    out_data.second);
        check_field("minute",    exp_t.minute,    out_data.minute);
        check_field("hour",      exp_t.hour,      out_data.hour);
        check_field("day",       exp_t.day,       out_data.day);
        check_field("month",     exp_t.month,     out_data.month);
        check_field("year",      exp_t.year,      out_data.year);
        check_field("set_error", exp_t.set_error, out_data.set_error);
      end
    end
  end

  // result side back-pressure
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        stall_left = $urandom_range(0, 6);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_word(input ccly_in_t w);
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic ccly_in_t make_set(input int s, input int mi, input int h,
                                        input int d, input int mo, input int y);
    ccly_in_t w;
    w.opcode     = OP_SET;
    w.set_second = 6'(s);
    w.set_minute = 6'(mi);
    w.set_hour   = 5'(h);
    w.set_day    = 5'(d);
    w.set_month  = 4'(mo);
    w.set_year   = 16'(y);
    return w;
  endfunction

  // tick with junk in the set fields
  function automatic ccly_in_t tick_word();
    logic [63:0] r;
    ccly_in_t    w;
    r = {$urandom, $urandom};
    w = r[$bits(ccly_in_t)-1:0];
    w.opcode = OP_TICK;
    return w;
  endfunction

  // valid set close to a carry boundary
  function automatic ccly_in_t boundary_set();
    logic [15:0] y;
    logic [3:0]  mo;
    logic [4:0]  len;
    int          s, mi, h, d;
    case ($urandom_range(0, 4))
      0:       y = 16'($urandom_range(0, 65535));
      1:       y = 16'($urandom_range(0, 163) * 400);
      2:       y = 16'($urandom_range(0, 655) * 100);
      3:       y = 16'($urandom_range(0, 16383) * 4);
      default: y = 16'hFFFF - 16'($urandom_range(0, 1));
    endcase
    mo  = ($urandom_range(0, 3) == 0) ? 4'd11 : 4'($urandom_range(0, 11));
    len = month_days(mo, y);
    s   = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 59) : 59 - $urandom_range(0, 2);
    mi  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 59) : 59;
    h   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 23) : 23;
    d   = ($urandom_range(0, 2) == 0) ? $urandom_range(0, len - 1) : len - 1;
    return make_set(s, mi, h, d, mo, y);
  endfunction

  function automatic ccly_in_t bad_set();
    ccly_in_t    w;
    logic [63:0] r;
    w = boundary_set();
    case ($urandom_range(0, 5))
      0: w.set_second = 6'($urandom_range(60, 63));
      1: w.set_minute = 6'($urandom_range(60, 63));
      2: w.set_hour   = 5'($urandom_range(24, 31));
      3: w.set_day    = 5'($urandom_range(month_days(w.set_month, w.set_year), 31));
      4: w.set_month  = 4'($urandom_range(12, 15));
      default: begin
        r = {$urandom, $urandom};
        w = r[$bits(ccly_in_t)-1:0];
        w.opcode = OP_SET;
      end
    endcase
    return w;
  endfunction

  task automatic run_calendar_mix(input int n_words);
    int          sent;
    int          ticks;
    int          kind;
    logic [63:0] r;
    sent = 0;
    while (sent < n_words) begin
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        send_word(boundary_set());
        sent++;
        ticks = $urandom_range(1, 8);
        repeat (ticks) begin
          send_word(tick_word());
          sent++;
        end
      end else if (kind < 8) begin
        send_word(bad_set());
        sent++;
      end else begin
        r = {$urandom, $urandom};
        send_word(r[$bits(ccly_in_t)-1:0]);
        sent++;
      end
    end
  endtask

  task automatic test_reset_state();
    ccly_in_t w;
    send_word(tick_word());
    w = '1;
    w.opcode = OP_TICK;
    send_word(w);
  endtask

  task automatic test_set_extremes();
    ccly_in_t w;
    w = '1;
    send_word(w);
    send_word(make_set(0, 0, 0, 0, 0, 0));
    send_word(make_set(59, 59, 23, 30, 11, 65535));
    send_word(tick_word());
    send_word(make_set(10, 10, 10, 10, 12, 2000));
    send_word(make_set(10, 10, 24, 10, 5, 2000));
    send_word(make_set(10, 60, 10, 10, 5, 2000));
    send_word(make_set(60, 10, 10, 10, 5, 2000));
    send_word(make_set(10, 10, 10, 30, 3, 2000));
    send_word(make_set(10, 10, 10, 29, 3, 2000));
  endtask

  task automatic test_leap_february();
    send_word(make_set(0, 0, 0, 28, 1, 2000));
    send_word(make_set(0, 0, 0, 28, 1, 1900));
    send_word(make_set(0, 0, 0, 28, 1, 2023));
    send_word(make_set(59, 59, 23, 28, 1, 2024));
    send_word(tick_word());
    send_word(make_set(59, 59, 23, 27, 1, 2023));
    send_word(tick_word());
    send_word(make_set(0, 0, 24, 28, 1, 2024));
    send_word(make_set(0, 60, 0, 28, 1, 2024));
    send_word(make_set(60, 0, 0, 28, 1, 2024));
    send_word(make_set(0, 0, 0, 28, 1, 0));
  endtask

  task automatic test_random_calendar();
    run_calendar_mix(360);
  endtask

  task automatic test_steady_stream();
    idle_on = 1'b0;
    run_calendar_mix(65);
  endtask

  initial begin
    int drain;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_set_extremes();
    test_leap_february();
    test_random_calendar();
    test_steady_stream();
    in_valid <= 1'b0;
    while (expected_time_q.size() != 0) @(posedge clk);
    drain = 10;
    repeat (drain) @(posedge clk);
    if (!failed && expected_time_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== calendar_clock_leap_year.f =====
sv/ccly_pkg.sv
sv/ccly_core.sv
sv/calendar_clock_leap_year.sv
sv/ccly_checker.sv
tb/tb_top.sv
